>>> hw/rtl/kac_pkg.sv
// shared types, codes and sizes for the keypad alarm controller
// no dependencies; imported by every module of the block
`default_nettype none

package kac_pkg;

  // code length and derived sizes
  localparam int CODE_DIGITS = 4;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  // fixed field widths
  localparam int LIMIT_W  = 10;
  localparam int DIGITS_W = 3;
  localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 10'd100;

  // action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_KEY    = 2'd1;
  localparam logic [1:0] ACT_MOTION = 2'd2;

  // key codes
  localparam logic [3:0] KEY_0    = 4'd0;
  localparam logic [3:0] KEY_9    = 4'd9;
  localparam logic [3:0] KEY_B    = 4'd11;
  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  typedef enum logic [1:0] {
    MODE_SOUNDING = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_DISARMED = 2'd2,
    MODE_CHANGE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CORRECT   = 3'd1,
    EV_INCORRECT = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_CHANGED   = 3'd4
  } event_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] key_code;
    logic       motion_seen;
  } item_t;

  typedef struct packed {
    mode_t               mode;
    logic [DIGITS_W-1:0] digits_entered;
    logic                buzzer_on;
    logic                armed_lamp;
    logic                wrong_code_flag;
    event_t              event_res;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/kac_in_stage.sv
// input register of the keypad alarm controller
// depends on kac_pkg for the item type
`default_nettype none

module kac_in_stage import kac_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic [1:0] s_tuser,
  input  wire logic       advance,
  output logic            item_vld,
  output item_t           item
);

  assign s_tready = !item_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (s_tready) begin
      item_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.action      <= s_tuser;
      item.key_code    <= s_tdata[3:0];
      item.motion_seen <= s_tdata[4];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kac_core.sv
// panel state and combinational next-state update for one item
// depends on kac_pkg for codes, types and code length
`default_nettype none

module kac_core import kac_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire item_t              item,
  input  wire logic [LIMIT_W-1:0] timeout_limit,
  output result_t                 result
);

  mode_t              mode_reg;
  mode_t              mode_next;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   count_next;
  logic [LIMIT_W-1:0] idle_ticks;
  logic [LIMIT_W-1:0] idle_next;
  logic               wrong_flag;
  logic               wrong_next;
  logic [3:0]         entry_digits [CODE_DIGITS];
  logic [3:0]         stored_code [CODE_DIGITS];
  logic [LIMIT_W:0]   tick_sum;
  logic               full;
  logic               match;
  logic               wr_digit;
  logic               load_code;
  event_t             ev;

  assign full     = (entry_count == CNT_W'(CODE_DIGITS));
  assign tick_sum = {1'b0, idle_ticks} + {{LIMIT_W{1'b0}}, 1'b1};

  always_comb begin
    match = full;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_digits[i] != stored_code[i]) match = 1'b0;
    end
  end

  always_comb begin
    mode_next  = mode_reg;
    count_next = entry_count;
    idle_next  = idle_ticks;
    wrong_next = wrong_flag;
    wr_digit   = 1'b0;
    load_code  = 1'b0;
    ev         = EV_NONE;
    unique case (item.action)
      ACT_TICK: begin
        if (tick_sum > {1'b0, timeout_limit}) begin
          if (entry_count != '0) ev = EV_TIMEOUT;
          count_next = '0;
          idle_next  = '0;
        end else begin
          idle_next = tick_sum[LIMIT_W-1:0];
        end
      end
      ACT_KEY: begin
        idle_next = '0;
        unique case (item.key_code) inside
          [KEY_0:KEY_9]: begin
            if (!full) begin
              wr_digit   = 1'b1;
              count_next = entry_count + CNT_W'(1);
            end
          end
          KEY_STAR: begin
            if (entry_count != '0) count_next = entry_count - CNT_W'(1);
          end
          KEY_B: begin
            if (mode_reg == MODE_DISARMED) begin
              mode_next  = MODE_CHANGE;
              count_next = '0;
            end
          end
          KEY_HASH: begin
            if (mode_reg == MODE_CHANGE) begin
              if (full) begin
                load_code = 1'b1;
                mode_next = MODE_DISARMED;
                ev        = EV_CHANGED;
              end
              count_next = '0;
            end else begin
              ev = match ? EV_CORRECT : EV_INCORRECT;
              case (mode_reg)
                MODE_ARMED: begin
                  mode_next  = match ? MODE_DISARMED : MODE_SOUNDING;
                  wrong_next = !match;
                  count_next = '0;
                end
                MODE_SOUNDING: begin
                  if (match) begin
                    mode_next  = MODE_DISARMED;
                    wrong_next = 1'b0;
                    count_next = '0;
                  end
                end
                default: begin
                  if (match) begin
                    mode_next  = MODE_ARMED;
                    count_next = '0;
                  end
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      ACT_MOTION: begin
        if (item.motion_seen && mode_reg == MODE_ARMED) begin
          mode_next  = MODE_SOUNDING;
          wrong_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_ARMED;
      entry_count <= '0;
      idle_ticks  <= '0;
      wrong_flag  <= 1'b0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_code[i] <= 4'((i % 9) + 1);
      end
    end else if (step) begin
      mode_reg    <= mode_next;
      entry_count <= count_next;
      idle_ticks  <= idle_next;
      wrong_flag  <= wrong_next;
      if (load_code) begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
          stored_code[i] <= entry_digits[i];
        end
      end
    end
  end

  // entry digits hold no reset, only slots below the count are read
  always_ff @(posedge clk) begin
    if (step && wr_digit) begin
      entry_digits[entry_count[IDX_W-1:0]] <= item.key_code;
    end
  end

  assign result.mode            = mode_next;
  assign result.digits_entered  = DIGITS_W'(count_next);
  assign result.buzzer_on       = (mode_next == MODE_SOUNDING);
  assign result.armed_lamp      = (mode_next == MODE_SOUNDING) || (mode_next == MODE_ARMED);
  assign result.wrong_code_flag = wrong_next;
  assign result.event_res       = ev;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CODE_DIGITS))
    else $error("entry count above code length");

  a_wrong_sounding: assert property (@(posedge clk) disable iff (rst)
    wrong_flag |-> mode_reg == MODE_SOUNDING)
    else $error("wrong code flag outside sounding mode");

  a_changed_disarms: assert property (@(posedge clk) disable iff (rst)
    step && ev == EV_CHANGED |=> mode_reg == MODE_DISARMED && entry_count == '0)
    else $error("code change did not end disarmed with empty entry");

  a_idle_step_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(mode_reg) && $stable(entry_count) && $stable(wrong_flag))
    else $error("state moved without an item");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/keypad_alarm_controller_unit.sv
// top level of the keypad alarm controller: config register and result register
// depends on kac_pkg, kac_in_stage and kac_core
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tuser action, s_tdata key_code, motion_seen
// m_*      out  m_tvalid / m_tready    m_tdata mode .. event_res
// cfg_*    in   cfg_valid / cfg_ready  cfg_data timeout_limit
//
// one word per cycle sustained while m_tready is high; a taken word lands in the input register,
// then passes the single state-update step into the result register, which drives m_tdata
// reset returns armed mode, code 1234, empty entry and timeout limit 100, no clearing pass
// a stalled result holds in the result register while one more word waits in the input
// register; s_tready drops only when both are full and m_tready is low
`default_nettype none

module keypad_alarm_controller_unit import kac_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // input stream
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,   // key_code[3:0], motion_seen[4], zero pad
  input  wire logic [1:0]         s_tuser,   // action[1:0]
  // result stream
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [15:0]             m_tdata,   // mode[1:0], digits_entered[4:2], buzzer_on[5],
                                             // armed_lamp[6], wrong_code_flag[7],
                                             // event_res[10:8], zero pad
  // config write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data   // timeout_limit
);

  logic               item_vld;
  item_t              item;
  logic               advance;
  logic [LIMIT_W-1:0] timeout_limit;
  result_t            result;
  result_t            res_q;

  // word moves into the result register when that register is free or draining
  assign advance = item_vld && (!m_tvalid || m_tready);

  // config always accepted; the user must let it land only while the block is quiet; no check
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_limit <= cfg_data;
    end
  end

  kac_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  // panel state steps exactly once per word, as it enters the result register
  kac_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item),
    .timeout_limit (timeout_limit),
    .result        (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_tdata = {5'b0, res_q.event_res, res_q.wrong_code_flag, res_q.armed_lamp,
                    res_q.buzzer_on, res_q.digits_entered, res_q.mode};

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result lost or changed");

  a_advance_frees: assert property (@(posedge clk) disable iff (rst)
    item_vld && !advance |-> m_tvalid && !m_tready)
    else $error("buffered word stuck while result side is free");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !item_vld |-> s_tready)
    else $error("input not ready with empty input register");
`endif

endmodule

`default_nettype wire

>>> dv/keypad_alarm_controller_unit_test.sv
// self-checking testbench for keypad_alarm_controller_unit: directed table, then random bursts
// depends on kac_pkg and the rtl of the block; carries its own status predictor
// stream sides idle at random, long result hold-offs now and then fill the block and stall its input
`default_nettype none

module keypad_alarm_controller_unit_test import kac_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_WORDS  = 240;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_CYCLES  = 60;
  localparam int HOLD_EVERY   = 500;
  localparam int DIR_ROWS     = 26;

  // keys the package does not name
  localparam logic [3:0] KEY_A = 4'd10;
  localparam logic [3:0] KEY_C = 4'd12;
  localparam logic [3:0] KEY_D = 4'd13;

  typedef struct {
    item_t   it;
    bit      typed;   // res holds a hand-written status for this row
    result_t res;
  } dir_row_t;

  localparam result_t NO_RES = '{MODE_ARMED, 3'd0, 1'b0, 1'b0, 1'b0, EV_NONE};

  // directed walk: reset status, full entry, delete, disarm, code change, arm, alarm
  dir_row_t dir_table [DIR_ROWS] = '{
    '{'{ACT_TICK,   KEY_0,    1'b0}, 1'b1, '{MODE_ARMED,    3'd0, 1'b0, 1'b1, 1'b0, EV_NONE}},
    '{'{ACT_KEY,    4'd1,     1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    4'd2,     1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    4'd3,     1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    4'd4,     1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_9,    1'b0}, 1'b1, '{MODE_ARMED,    3'd4, 1'b0, 1'b1, 1'b0, EV_NONE}},
    '{'{ACT_KEY,    KEY_STAR, 1'b0}, 1'b1, '{MODE_ARMED,    3'd3, 1'b0, 1'b1, 1'b0, EV_NONE}},
    '{'{ACT_KEY,    4'd4,     1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_HASH, 1'b0}, 1'b1, '{MODE_DISARMED, 3'd0, 1'b0, 1'b0, 1'b0, EV_CORRECT}},
    '{'{ACT_KEY,    KEY_A,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_D,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_B,    1'b0}, 1'b1, '{MODE_CHANGE,   3'd0, 1'b0, 1'b0, 1'b0, EV_NONE}},
    '{'{ACT_KEY,    KEY_0,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_9,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_0,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_9,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_HASH, 1'b0}, 1'b1, '{MODE_DISARMED, 3'd0, 1'b0, 1'b0, 1'b0, EV_CHANGED}},
    '{'{ACT_KEY,    KEY_STAR, 1'b0}, 1'b1, '{MODE_DISARMED, 3'd0, 1'b0, 1'b0, 1'b0, EV_NONE}},
    '{'{ACT_KEY,    KEY_HASH, 1'b0}, 1'b1, '{MODE_DISARMED, 3'd0, 1'b0, 1'b0, 1'b0, EV_INCORRECT}},
    '{'{ACT_KEY,    KEY_0,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_9,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_0,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_9,    1'b0}, 1'b0, NO_RES},
    '{'{ACT_KEY,    KEY_HASH, 1'b0}, 1'b1, '{MODE_ARMED,    3'd0, 1'b0, 1'b1, 1'b0, EV_CORRECT}},
    '{'{ACT_MOTION, KEY_0,    1'b1}, 1'b1, '{MODE_SOUNDING, 3'd0, 1'b1, 1'b1, 1'b0, EV_NONE}},
    '{'{ACT_KEY,    KEY_HASH, 1'b0}, 1'b1, '{MODE_SOUNDING, 3'd0, 1'b1, 1'b1, 1'b0, EV_INCORRECT}}
  };

  // dut signals, all inputs known from time zero
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata   = '0;   // key_code[3:0], motion_seen[4], zero pad
  logic [1:0]         s_tuser   = '0;   // action[1:0]
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [15:0]        m_tdata;          // mode[1:0], digits_entered[4:2], buzzer_on[5],
                                        // armed_lamp[6], wrong_code_flag[7], event_res[10:8]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data  = '0;

  // predictor state, mirrors the panel after every accepted word
  mode_t                        pm_mode;
  logic [CODE_DIGITS-1:0][3:0]  pm_entry;
  logic [CODE_DIGITS-1:0][3:0]  pm_code;
  int                           pm_count;
  int                           pm_idle;
  logic                         pm_wrong;
  int                           pm_limit;

  // expected statuses, oldest first
  result_t status_q [$];

  int  err_cnt       = 0;
  int  words_sent    = 0;
  int  words_seen    = 0;
  int  holds_done    = 0;
  int  cnt_timeout   = 0;
  int  cnt_changed   = 0;
  int  cnt_correct   = 0;
  int  cnt_incorrect = 0;
  bit  snd_idle_on   = 1'b1;
  bit  rcv_idle_on   = 1'b1;

  keypad_alarm_controller_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // next status of the panel for one word; updates the predictor state
  function automatic result_t predict_status(item_t it);
    result_t r;
    event_t  ev;
    int      nxt;
    bit      ok;
    ev = EV_NONE;
    case (it.action)
      ACT_TICK: begin
        nxt = pm_idle + 1;
        if (nxt > pm_limit) begin
          if (pm_count > 0) ev = EV_TIMEOUT;
          pm_count = 0;
          pm_idle  = 0;
        end else begin
          pm_idle = nxt;
        end
      end
      ACT_KEY: begin
        // any key restarts the idle count
        pm_idle = 0;
        if (it.key_code <= KEY_9) begin
          if (pm_count < CODE_DIGITS) begin
            pm_entry[pm_count] = it.key_code;
            pm_count++;
          end
        end else if (it.key_code == KEY_STAR) begin
          if (pm_count > 0) pm_count--;
        end else if (it.key_code == KEY_B) begin
          if (pm_mode == MODE_DISARMED) begin
            pm_mode  = MODE_CHANGE;
            pm_count = 0;
          end
        end else if (it.key_code == KEY_HASH) begin
          if (pm_mode == MODE_CHANGE) begin
            // new code only from a full entry, entry dropped either way
            if (pm_count == CODE_DIGITS) begin
              pm_code = pm_entry;
              pm_mode = MODE_DISARMED;
              ev      = EV_CHANGED;
            end
            pm_count = 0;
          end else begin
            ok = (pm_count == CODE_DIGITS) && (pm_entry == pm_code);
            ev = ok ? EV_CORRECT : EV_INCORRECT;
            if (pm_mode == MODE_ARMED) begin
              pm_mode  = ok ? MODE_DISARMED : MODE_SOUNDING;
              pm_wrong = !ok;
              pm_count = 0;
            end else if (ok) begin
              if (pm_mode == MODE_SOUNDING) begin
                pm_mode  = MODE_DISARMED;
                pm_wrong = 1'b0;
              end else begin
                pm_mode = MODE_ARMED;
              end
              pm_count = 0;
            end
          end
        end
      end
      ACT_MOTION: begin
        if (it.motion_seen && pm_mode == MODE_ARMED) begin
          pm_mode  = MODE_SOUNDING;
          pm_wrong = 1'b0;
        end
      end
      default: ;
    endcase
    r.mode            = pm_mode;
    r.digits_entered  = DIGITS_W'(pm_count);
    r.buzzer_on       = (pm_mode == MODE_SOUNDING);
    r.armed_lamp      = (pm_mode == MODE_SOUNDING) || (pm_mode == MODE_ARMED);
    r.wrong_code_flag = pm_wrong;
    r.event_res       = ev;
    return r;
  endfunction

  // offer one word, wait for the handshake, then queue its status
  task automatic send_word(item_t it, bit typed, result_t typed_res);
    int      gap;
    result_t r;
    gap = snd_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it.motion_seen, it.key_code};
    s_tuser  <= it.action;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_status(it);
    if (typed) r = typed_res;
    case (r.event_res)
      EV_TIMEOUT:   cnt_timeout++;
      EV_CHANGED:   cnt_changed++;
      EV_CORRECT:   cnt_correct++;
      EV_INCORRECT: cnt_incorrect++;
      default: ;
    endcase
    status_q.push_back(r);
    words_sent++;
  endtask

  // timeout limit is only touched with the pipe empty and settled
  task automatic write_limit(int lim);
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= LIMIT_W'(lim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pm_limit = lim;
  endtask

  // one random burst: mostly well-formed code entries with random content
  task automatic send_burst();
    item_t burst [$];
    item_t it;
    int    pick;
    int    n;
    int    pos;
    pick = $urandom_range(0, 99);
    it.motion_seen = 1'b0;
    it.action      = ACT_KEY;
    if (pick < 30) begin
      // the stored code, now and then with a typo fixed by star
      pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : CODE_DIGITS;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (i == pos) begin
          it.key_code = 4'($urandom_range(0, 9));
          burst.push_back(it);
          it.key_code = KEY_STAR;
          burst.push_back(it);
        end
        it.key_code = pm_code[i];
        burst.push_back(it);
      end
      it.key_code = KEY_HASH;
      burst.push_back(it);
    end else if (pick < 45) begin
      // guess of random length, short, full or overlong
      n = $urandom_range(0, 5);
      repeat (n) begin
        it.key_code = 4'($urandom_range(0, 9));
        burst.push_back(it);
      end
      it.key_code = KEY_HASH;
      burst.push_back(it);
    end else if (pick < 55) begin
      // code change attempt
      it.key_code = KEY_B;
      burst.push_back(it);
      n = $urandom_range(3, 5);
      repeat (n) begin
        it.key_code = 4'($urandom_range(0, 9));
        burst.push_back(it);
      end
      if ($urandom_range(0, 3) == 0) begin
        it.key_code = KEY_STAR;
        burst.push_back(it);
      end
      it.key_code = KEY_HASH;
      burst.push_back(it);
    end else if (pick < 65) begin
      it.action      = ACT_MOTION;
      it.key_code    = 4'($urandom_range(0, 15));
      it.motion_seen = 1'($urandom_range(0, 1));
      burst.push_back(it);
    end else if (pick < 80) begin
      // tick run, long enough to time out where the limit allows
      if (pm_limit <= 24) n = $urandom_range(1, pm_limit + 2);
      else if (pm_limit <= 120 && $urandom_range(0, 9) == 0) n = pm_limit + 1;
      else n = $urandom_range(1, 6);
      it.action = ACT_TICK;
      repeat (n) begin
        it.key_code    = 4'($urandom_range(0, 15));
        it.motion_seen = 1'($urandom_range(0, 1));
        burst.push_back(it);
      end
    end else begin
      // noise: any action, any key
      n = $urandom_range(1, 3);
      repeat (n) begin
        it.action      = 2'($urandom_range(0, 2));
        it.key_code    = 4'($urandom_range(0, 15));
        it.motion_seen = 1'($urandom_range(0, 1));
        burst.push_back(it);
      end
    end
    foreach (burst[i]) send_word(burst[i], 1'b0, NO_RES);
  endtask

  // stimulus: reset, directed table, then random phases at several limits
  initial begin
    int phase_lims [NUM_PHASES];
    int phase_words;
    pm_mode  = MODE_ARMED;
    pm_entry = '0;
    pm_count = 0;
    pm_idle  = 0;
    pm_wrong = 1'b0;
    pm_limit = int'(TIMEOUT_RESET);
    for (int i = 0; i < CODE_DIGITS; i++) pm_code[i] = 4'((i % 9) + 1);
    phase_lims = '{1, 1023, 7, $urandom_range(2, 40), 100, 2};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_table[i].it, dir_table[i].typed, dir_table[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_lims[p]);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        // now and then switch between idling and back-to-back sending
        if ($urandom_range(0, 7) == 0) snd_idle_on = !snd_idle_on;
        phase_words -= words_sent;
        send_burst();
        phase_words += words_sent;
      end
    end

    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d words over %0d limit settings, %0d long result holds", words_sent,
             NUM_PHASES + 1, holds_done);
    $display("codes correct %0d, incorrect %0d, changed %0d, entry timeouts %0d",
             cnt_correct, cnt_incorrect, cnt_changed, cnt_timeout);
    if (err_cnt == 0) begin
      $display("keypad_alarm_controller_unit_test: clean");
    end else begin
      $display("keypad_alarm_controller_unit_test: errors");
    end
    $finish;
  end

  // result side: random stalls, plus a long hold-off every so often
  initial begin
    int wait_n;
    int next_hold;
    next_hold = HOLD_EVERY / 2;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rcv_idle_on = !rcv_idle_on;
      wait_n = rcv_idle_on ? $urandom_range(0, 5) : 0;
      if (words_seen >= next_hold) begin
        // long stall: the sender keeps offering, so the block fills and backs up
        wait_n    = HOLD_CYCLES;
        next_hold = next_hold + HOLD_EVERY;
        holds_done++;
      end
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // checker: every taken result word against the oldest expected status
  always @(posedge clk) begin
    result_t e;
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (status_q.size() == 0) begin
        $display("%0t: result word with none expected, actual %h", $time, m_tdata);
        err_cnt++;
      end else begin
        e = status_q.pop_front();
        check_field("mode",            int'(e.mode),            int'(m_tdata[1:0]));
        check_field("digits_entered",  int'(e.digits_entered),  int'(m_tdata[4:2]));
        check_field("buzzer_on",       int'(e.buzzer_on),       int'(m_tdata[5]));
        check_field("armed_lamp",      int'(e.armed_lamp),      int'(m_tdata[6]));
        check_field("wrong_code_flag", int'(e.wrong_code_flag), int'(m_tdata[7]));
        check_field("event_res",       int'(e.event_res),       int'(m_tdata[10:8]));
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(2_400_000);
    $display("%0t: timeout with %0d results outstanding", $time, status_q.size());
    $display("keypad_alarm_controller_unit_test: errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/kac_pkg.sv
hw/rtl/kac_in_stage.sv
hw/rtl/kac_core.sv
hw/rtl/keypad_alarm_controller_unit.sv
dv/keypad_alarm_controller_unit_test.sv
